// ===== src/svg_pkg.sv =====
// Shared types, constants and tables of the spiral vertex generator.
package svg_pkg;

   // Fixed-point format of pixels, radii, spacings, turns and arc position.
   localparam int FRAC_BITS = 8;

   // Divider numerator width: a 29-bit radius difference shifted by 2F.
   localparam int DIV_W = 29 + 2 * FRAC_BITS;
   localparam int DIV_STEPS = DIV_W;
   localparam int SQRT_STEPS = 32;
   localparam int MAX_CORDIC_STEPS = 24;
   localparam int CNT_W = 6;
   localparam int IDX_W = 5;

   localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
   localparam logic [17:0] PI_Q16 = 18'd205887;
   localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_CENTER_X      = 3'd0,
      REG_CENTER_Y      = 3'd1,
      REG_INNER_RADIUS  = 3'd2,
      REG_OUTER_RADIUS  = 3'd3,
      REG_TURN_COUNT    = 3'd4,
      REG_SPACING_START = 3'd5,
      REG_SPACING_END   = 3'd6
   } reg_index_type;

   // Datapath operations issued by the controller.
   typedef enum logic [4:0] {
      OP_NONE,
      OP_BAD,
      OP_LD_DR,
      OP_LD_SR,
      OP_LD_D,
      OP_DIV_STEP,
      OP_MUL_QHI,
      OP_MUL_QLO,
      OP_SET_DR,
      OP_SET_SR,
      OP_MUL_TPI,
      OP_MUL_LEN,
      OP_SET_LEN,
      OP_MUL_R1SQ,
      OP_MUL_DRD,
      OP_SQ_LD,
      OP_SQ_STEP,
      OP_MUL_PHASE,
      OP_COR_LD,
      OP_COR_STEP,
      OP_MUL_CX,
      OP_MUL_SY,
      OP_MUL_INC,
      OP_ADV
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic bad_radii;
      logic finished;
   } status_type;

   typedef struct packed {
      logic        en;
      logic [2:0]  index;
      logic [23:0] data;
   } cfg_write_type;

   // Arctangent of 2^-i as a fraction of a full turn, 2^32 per turn.
   function automatic logic signed [33:0] atan_entry(input logic [IDX_W-1:0] i);
      logic signed [33:0] v;
      case (i)
         5'd0:  v = 34'sd536870912;
         5'd1:  v = 34'sd316933406;
         5'd2:  v = 34'sd167458907;
         5'd3:  v = 34'sd85004756;
         5'd4:  v = 34'sd42667331;
         5'd5:  v = 34'sd21354465;
         5'd6:  v = 34'sd10679838;
         5'd7:  v = 34'sd5340245;
         5'd8:  v = 34'sd2670163;
         5'd9:  v = 34'sd1335087;
         5'd10: v = 34'sd667544;
         5'd11: v = 34'sd333772;
         5'd12: v = 34'sd166886;
         5'd13: v = 34'sd83443;
         5'd14: v = 34'sd41722;
         5'd15: v = 34'sd20861;
         5'd16: v = 34'sd10430;
         5'd17: v = 34'sd5215;
         5'd18: v = 34'sd2608;
         5'd19: v = 34'sd1304;
         5'd20: v = 34'sd652;
         5'd21: v = 34'sd326;
         5'd22: v = 34'sd163;
         5'd23: v = 34'sd81;
         default: v = 34'sd0;
      endcase
      return v;
   endfunction

endpackage

// ===== src/svg_if.sv =====
// Channel interfaces for requests, vertex results and register writes.
interface svg_req_if;
   logic valid;
   logic ready;
   logic restart;
   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface svg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] vertex_x;
   logic signed [23:0] vertex_y;
   logic               last_vertex;
   logic               bad_radii;
   modport source (output valid, output vertex_x, output vertex_y,
                   output last_vertex, output bad_radii, input ready);
   modport sink (input valid, input vertex_x, input vertex_y,
                 input last_vertex, input bad_radii, output ready);
endinterface

interface svg_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [23:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/spiral_vertex_generator_core.sv =====
// Top level: a vertex passes the 32-step square root, the 45-step divider and CORDIC_STEPS
// rotation steps between accepted request and result.
// A request that starts a new walk first runs two more 45-step divisions.
// With bad radii the request goes to ST_BAD, which issues the result once the result slot is free.
// One vertex is in work at a time; the controller returns to idle as it issues a result, then takes the next request.
// Synchronous reset restores register defaults and forces a new walk on the next request.
module spiral_vertex_generator_core import svg_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input logic        clock,
   input logic        reset,
   svg_req_if.sink    req_ch,
   svg_rsp_if.source  rsp_ch,
   svg_csr_if.sink    csr_ch
);

   cfg_write_type cfg_wr;
   cmd_type       cmd;
   status_type    status;

   // Register writes are always taken.
   assign csr_ch.ready = 1'b1;
   assign cfg_wr.en    = csr_ch.valid;
   assign cfg_wr.index = csr_ch.index;
   assign cfg_wr.data  = csr_ch.data;

   svg_control #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_control (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_restart (req_ch.restart),
      .req_ready   (req_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .status      (status),
      .cmd         (cmd)
   );

   svg_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg_wr      (cfg_wr),
      .cmd         (cmd),
      .status      (status),
      .vertex_x    (rsp_ch.vertex_x),
      .vertex_y    (rsp_ch.vertex_y),
      .last_vertex (rsp_ch.last_vertex),
      .bad_radii   (rsp_ch.bad_radii)
   );

endmodule

// ===== src/svg_datapath.sv =====
// Datapath: registers, shared multiplier, divider, square root and CORDIC.
module svg_datapath import svg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_write_type      cfg_wr,
   input  cmd_type            cmd,
   output status_type         status,
   output logic signed [23:0] vertex_x,
   output logic signed [23:0] vertex_y,
   output logic               last_vertex,
   output logic               bad_radii
);

   localparam int LEN_SH = 16 + FRAC_BITS;

   function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
      logic signed [23:0] r;
      if (v > 40'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -40'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

   // Configuration registers.
   logic signed [23:0] cx_ff, cy_ff;
   logic [23:0]        ri_ff, ro_ff;
   logic [15:0]        turns_ff, ss_ff, se_ff;

   // Walk state.
   logic [31:0]        arc_ff, total_ff, rate_ff;
   logic signed [31:0] srate_ff;
   logic               finished_ff;

   // Work registers.
   logic signed [67:0] prod_ff;
   logic [43:0]        hi_ff;
   logic [47:0]        acc_ff;
   logic [63:0]        sv_ff, res_ff;
   logic [31:0]        rem_ff, dvs_ff;
   logic [DIV_W-1:0]   quo_ff;
   logic [30:0]        d_ff;
   logic signed [33:0] xc_ff, yc_ff, zc_ff;
   logic [1:0]         quad_ff;
   logic signed [23:0] xr_ff, yr_ff;

   // Result registers.
   logic signed [23:0] out_x_ff, out_y_ff;
   logic               out_last_ff, out_bad_ff;

   logic [15:0]        turns_eff, mag;
   logic [23:0]        delta;
   logic               ds_neg;
   logic [31:0]        r_val, diff, div_by;
   logic [24:0]        radius_sum;
   logic [44:0]        ot_sum;
   logic [30:0]        d_sat;
   logic [31:0]        phase;
   logic signed [34:0] mul_a, cos_v, sin_v;
   logic signed [32:0] mul_b;
   logic signed [67:0] mul_p, rnd_full, inc_full;
   logic signed [39:0] rnd, px_w, py_w;
   logic signed [49:0] inc_w, nd_w;
   logic [31:0]        nd_c;
   logic [32:0]        trial;
   logic [63:0]        sq_bit, sq_sum;
   logic signed [33:0] xs, ys, atan_v;

   assign status.bad_radii = !(ro_ff > ri_ff);
   assign status.finished  = finished_ff;

   assign vertex_x    = out_x_ff;
   assign vertex_y    = out_y_ff;
   assign last_vertex = out_last_ff;
   assign bad_radii   = out_bad_ff;

   // Derived operands.
   always_comb begin
      turns_eff  = (turns_ff == 16'd0) ? 16'd1 : turns_ff;
      delta      = ro_ff - ri_ff;
      ds_neg     = se_ff < ss_ff;
      mag        = ds_neg ? (ss_ff - se_ff) : (se_ff - ss_ff);
      div_by     = (rate_ff == 32'd0) ? 32'd1 : rate_ff;
      r_val      = res_ff[31:0];
      diff       = (r_val > {8'd0, ri_ff}) ? (r_val - {8'd0, ri_ff}) : 32'd0;
      radius_sum = {1'b0, ri_ff} + {1'b0, ro_ff};
      ot_sum     = {1'b0, hi_ff} + {13'd0, prod_ff[63:32]};
      d_sat      = (|quo_ff[DIV_W-1:31]) ? 31'h7FFFFFFF : quo_ff[30:0];
      phase      = prod_ff[FRAC_BITS +: 32];
   end

   // Quadrant mapping of the CORDIC result.
   always_comb begin
      case (quad_ff)
         2'd0: begin
            cos_v = {xc_ff[33], xc_ff};
            sin_v = {yc_ff[33], yc_ff};
         end
         2'd1: begin
            cos_v = -{yc_ff[33], yc_ff};
            sin_v = {xc_ff[33], xc_ff};
         end
         2'd2: begin
            cos_v = -{xc_ff[33], xc_ff};
            sin_v = -{yc_ff[33], yc_ff};
         end
         default: begin
            cos_v = {yc_ff[33], yc_ff};
            sin_v = -{xc_ff[33], xc_ff};
         end
      endcase
   end

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MUL_QHI: begin
            mul_a = {22'd0, quo_ff[44:32]};
            mul_b = {3'd0, INV_TWO_PI_Q32};
         end
         OP_MUL_QLO: begin
            mul_a = {3'd0, quo_ff[31:0]};
            mul_b = {3'd0, INV_TWO_PI_Q32};
         end
         OP_MUL_TPI: begin
            mul_a = {19'd0, turns_eff};
            mul_b = {15'd0, PI_Q16};
         end
         OP_MUL_LEN: begin
            mul_a = {1'b0, prod_ff[33:0]};
            mul_b = {8'd0, radius_sum};
         end
         OP_MUL_R1SQ: begin
            mul_a = {11'd0, ri_ff};
            mul_b = {9'd0, ri_ff};
         end
         OP_MUL_DRD: begin
            mul_a = {3'd0, rate_ff};
            mul_b = {1'b0, arc_ff};
         end
         OP_MUL_PHASE: begin
            mul_a = {4'd0, d_sat};
            mul_b = {3'd0, INV_TWO_PI_Q32};
         end
         OP_MUL_CX: begin
            mul_a = cos_v;
            mul_b = {1'b0, r_val};
         end
         OP_MUL_SY: begin
            mul_a = sin_v;
            mul_b = {1'b0, r_val};
         end
         OP_MUL_INC: begin
            mul_a = {4'd0, d_ff};
            mul_b = {srate_ff[31], srate_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Rounded products, vertex coordinates and the arc advance.
   always_comb begin
      rnd_full = (prod_ff + 68'sd536870912) >>> 30;
      rnd      = rnd_full[39:0];
      px_w     = {{16{cx_ff[23]}}, cx_ff} - rnd;
      py_w     = {{16{cy_ff[23]}}, cy_ff} + rnd;
      inc_full = prod_ff >>> (2 * FRAC_BITS);
      inc_w    = {34'd0, ss_ff} + inc_full[49:0];
      nd_w     = {18'd0, arc_ff} + inc_w;
      if (nd_w[49]) begin
         nd_c = 32'd0;
      end else if (|nd_w[48:32]) begin
         nd_c = 32'hFFFFFFFF;
      end else begin
         nd_c = nd_w[31:0];
      end
   end

   // One step of the divider, the square root and the CORDIC rotation.
   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_W-1]};
      sq_bit = 64'd1 << (6'd62 - {cmd.idx, 1'b0});
      sq_sum = res_ff + sq_bit;
      xs     = xc_ff >>> cmd.idx;
      ys     = yc_ff >>> cmd.idx;
      atan_v = atan_entry(cmd.idx);
   end

   // Configuration registers take writes at any time.
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff    <= '0;
         cy_ff    <= '0;
         ri_ff    <= '0;
         ro_ff    <= 24'd25600;
         turns_ff <= 16'd256;
         ss_ff    <= 16'd256;
         se_ff    <= 16'd256;
      end else if (cfg_wr.en) begin
         case (cfg_wr.index)
            REG_CENTER_X:      cx_ff    <= cfg_wr.data;
            REG_CENTER_Y:      cy_ff    <= cfg_wr.data;
            REG_INNER_RADIUS:  ri_ff    <= cfg_wr.data;
            REG_OUTER_RADIUS:  ro_ff    <= cfg_wr.data;
            REG_TURN_COUNT:    turns_ff <= cfg_wr.data[15:0];
            REG_SPACING_START: ss_ff    <= cfg_wr.data[15:0];
            REG_SPACING_END:   se_ff    <= cfg_wr.data[15:0];
            default: ;
         endcase
      end
   end

   // Walk state.
   always_ff @(posedge clock) begin
      if (reset) begin
         arc_ff      <= '0;
         total_ff    <= '0;
         rate_ff     <= '0;
         srate_ff    <= '0;
         finished_ff <= 1'b1;
      end else begin
         case (cmd.op)
            OP_BAD: finished_ff <= 1'b1;
            OP_SET_DR: begin
               if (|ot_sum[44:32]) begin
                  rate_ff <= 32'hFFFFFFFF;
               end else if (ot_sum[31:0] == 32'd0) begin
                  rate_ff <= 32'd1;
               end else begin
                  rate_ff <= ot_sum[31:0];
               end
            end
            OP_SET_SR: begin
               if (ds_neg) begin
                  if (ot_sum > 45'h080000000) begin
                     srate_ff <= 32'sh80000000;
                  end else begin
                     srate_ff <= ~ot_sum[31:0] + 32'd1;
                  end
               end else if (ot_sum > 45'h07FFFFFFF) begin
                  srate_ff <= 32'sh7FFFFFFF;
               end else begin
                  srate_ff <= ot_sum[31:0];
               end
            end
            OP_SET_LEN: begin
               total_ff    <= (|prod_ff[66:LEN_SH+32]) ? 32'hFFFFFFFF
                                                       : prod_ff[LEN_SH +: 32];
               arc_ff      <= '0;
               finished_ff <= 1'b0;
            end
            OP_ADV: begin
               arc_ff      <= nd_c;
               finished_ff <= nd_c >= total_ff;
            end
            default: ;
         endcase
      end
   end

   // Arithmetic work registers.
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_MUL_QHI, OP_MUL_TPI, OP_MUL_LEN, OP_MUL_R1SQ, OP_MUL_PHASE,
         OP_MUL_CX: prod_ff <= mul_p;
         OP_MUL_QLO: begin
            hi_ff   <= prod_ff[43:0];
            prod_ff <= mul_p;
         end
         OP_MUL_DRD: begin
            acc_ff  <= prod_ff[47:0];
            prod_ff <= mul_p;
         end
         OP_MUL_SY: begin
            xr_ff   <= sat24(px_w);
            prod_ff <= mul_p;
         end
         OP_MUL_INC: begin
            yr_ff   <= sat24(py_w);
            prod_ff <= mul_p;
         end
         OP_LD_DR: begin
            quo_ff <= {{(DIV_W - 24 - 2 * FRAC_BITS){1'b0}}, delta,
                       {(2 * FRAC_BITS){1'b0}}};
            rem_ff <= '0;
            dvs_ff <= {16'd0, turns_eff};
         end
         OP_LD_SR: begin
            quo_ff <= {{(DIV_W - 16 - 2 * FRAC_BITS){1'b0}}, mag,
                       {(2 * FRAC_BITS){1'b0}}};
            rem_ff <= '0;
            dvs_ff <= {16'd0, turns_eff};
         end
         OP_LD_D: begin
            quo_ff <= {diff[DIV_W-2*FRAC_BITS-1:0], {(2 * FRAC_BITS){1'b0}}};
            rem_ff <= '0;
            dvs_ff <= div_by;
         end
         OP_DIV_STEP: begin
            if (trial >= {1'b0, dvs_ff}) begin
               rem_ff <= 32'(trial - {1'b0, dvs_ff});
               quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_ff <= trial[31:0];
               quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
            end
         end
         OP_SQ_LD: begin
            sv_ff  <= {16'd0, acc_ff} + 64'(prod_ff[63:FRAC_BITS-1]);
            res_ff <= '0;
         end
         OP_SQ_STEP: begin
            if (sv_ff >= sq_sum) begin
               sv_ff  <= sv_ff - sq_sum;
               res_ff <= (res_ff >> 1) + sq_bit;
            end else begin
               res_ff <= res_ff >> 1;
            end
         end
         OP_COR_LD: begin
            d_ff    <= d_ff;
            xc_ff   <= {4'd0, CORDIC_GAIN_Q30};
            yc_ff   <= '0;
            zc_ff   <= {4'd0, phase[29:0]};
            quad_ff <= phase[31:30];
         end
         OP_COR_STEP: begin
            if (!zc_ff[33]) begin
               xc_ff <= xc_ff - ys;
               yc_ff <= yc_ff + xs;
               zc_ff <= zc_ff - atan_v;
            end else begin
               xc_ff <= xc_ff + ys;
               yc_ff <= yc_ff - xs;
               zc_ff <= zc_ff + atan_v;
            end
         end
         default: ;
      endcase
      if (cmd.op == OP_MUL_PHASE) begin
         d_ff <= d_sat;
      end
   end

   // Result registers, loaded when the controller hands a result over.
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_BAD: begin
            out_x_ff    <= '0;
            out_y_ff    <= '0;
            out_last_ff <= 1'b1;
            out_bad_ff  <= 1'b1;
         end
         OP_ADV: begin
            out_x_ff    <= xr_ff;
            out_y_ff    <= yr_ff;
            out_last_ff <= nd_c >= total_ff;
            out_bad_ff  <= 1'b0;
         end
         default: ;
      endcase
   end

endmodule

// ===== src/svg_control.sv =====
// Controller: sequences the datapath through walk setup and vertex steps.
module svg_control import svg_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_restart,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [27:0] {
      ST_IDLE    = 28'h0000001,
      ST_BAD     = 28'h0000002,
      ST_LD_DR   = 28'h0000004,
      ST_DIV_DR  = 28'h0000008,
      ST_HI_DR   = 28'h0000010,
      ST_LO_DR   = 28'h0000020,
      ST_SET_DR  = 28'h0000040,
      ST_LD_SR   = 28'h0000080,
      ST_DIV_SR  = 28'h0000100,
      ST_HI_SR   = 28'h0000200,
      ST_LO_SR   = 28'h0000400,
      ST_SET_SR  = 28'h0000800,
      ST_TPI     = 28'h0001000,
      ST_LEN     = 28'h0002000,
      ST_SET_LEN = 28'h0004000,
      ST_R1SQ    = 28'h0008000,
      ST_DRD     = 28'h0010000,
      ST_SQ_LD   = 28'h0020000,
      ST_SQ      = 28'h0040000,
      ST_LD_D    = 28'h0080000,
      ST_DIV_D   = 28'h0100000,
      ST_PHASE   = 28'h0200000,
      ST_COR_LD  = 28'h0400000,
      ST_COR     = 28'h0800000,
      ST_MCX     = 28'h1000000,
      ST_MSY     = 28'h2000000,
      ST_MINC    = 28'h4000000,
      ST_ADV     = 28'h8000000
   } state_type;

   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
   localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);
   localparam logic [CNT_W-1:0] COR_LAST  = CNT_W'(CORDIC_STEPS - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free, issue;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == ST_IDLE);

   // Iterating states count steps and leave after the last one.
   function automatic logic step_done(input logic [CNT_W-1:0] c,
                                      input logic [CNT_W-1:0] last);
      return c == last;
   endfunction

   always_comb begin
      state_in = state_ff;
      cnt_in   = '0;
      cmd.op   = OP_NONE;
      cmd.idx  = cnt_ff[IDX_W-1:0];
      issue    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.bad_radii) begin
                  state_in = ST_BAD;
               end else if (req_restart || status.finished) begin
                  state_in = ST_LD_DR;
               end else begin
                  state_in = ST_R1SQ;
               end
            end
         end
         ST_BAD: begin
            if (slot_free) begin
               cmd.op   = OP_BAD;
               issue    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         // Radial rate: turn count division, then scale by one over two pi.
         ST_LD_DR: begin
            cmd.op   = OP_LD_DR;
            state_in = ST_DIV_DR;
         end
         ST_DIV_DR: begin
            cmd.op = OP_DIV_STEP;
            if (step_done(cnt_ff, DIV_LAST)) state_in = ST_HI_DR;
            else cnt_in = cnt_ff + 1'b1;
         end
         ST_HI_DR: begin
            cmd.op   = OP_MUL_QHI;
            state_in = ST_LO_DR;
         end
         ST_LO_DR: begin
            cmd.op   = OP_MUL_QLO;
            state_in = ST_SET_DR;
         end
         ST_SET_DR: begin
            cmd.op   = OP_SET_DR;
            state_in = ST_LD_SR;
         end
         // Spacing rate, the same way.
         ST_LD_SR: begin
            cmd.op   = OP_LD_SR;
            state_in = ST_DIV_SR;
         end
         ST_DIV_SR: begin
            cmd.op = OP_DIV_STEP;
            if (step_done(cnt_ff, DIV_LAST)) state_in = ST_HI_SR;
            else cnt_in = cnt_ff + 1'b1;
         end
         ST_HI_SR: begin
            cmd.op   = OP_MUL_QHI;
            state_in = ST_LO_SR;
         end
         ST_LO_SR: begin
            cmd.op   = OP_MUL_QLO;
            state_in = ST_SET_SR;
         end
         ST_SET_SR: begin
            cmd.op   = OP_SET_SR;
            state_in = ST_TPI;
         end
         // Total length.
         ST_TPI: begin
            cmd.op   = OP_MUL_TPI;
            state_in = ST_LEN;
         end
         ST_LEN: begin
            cmd.op   = OP_MUL_LEN;
            state_in = ST_SET_LEN;
         end
         ST_SET_LEN: begin
            cmd.op   = OP_SET_LEN;
            state_in = ST_R1SQ;
         end
         // Radius: square of the inner radius plus the arc term, then root.
         ST_R1SQ: begin
            cmd.op   = OP_MUL_R1SQ;
            state_in = ST_DRD;
         end
         ST_DRD: begin
            cmd.op   = OP_MUL_DRD;
            state_in = ST_SQ_LD;
         end
         ST_SQ_LD: begin
            cmd.op   = OP_SQ_LD;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            cmd.op = OP_SQ_STEP;
            if (step_done(cnt_ff, SQRT_LAST)) state_in = ST_LD_D;
            else cnt_in = cnt_ff + 1'b1;
         end
         // Angle by division, then phase and CORDIC rotation.
         ST_LD_D: begin
            cmd.op   = OP_LD_D;
            state_in = ST_DIV_D;
         end
         ST_DIV_D: begin
            cmd.op = OP_DIV_STEP;
            if (step_done(cnt_ff, DIV_LAST)) state_in = ST_PHASE;
            else cnt_in = cnt_ff + 1'b1;
         end
         ST_PHASE: begin
            cmd.op   = OP_MUL_PHASE;
            state_in = ST_COR_LD;
         end
         ST_COR_LD: begin
            cmd.op   = OP_COR_LD;
            state_in = ST_COR;
         end
         ST_COR: begin
            cmd.op = OP_COR_STEP;
            if (step_done(cnt_ff, COR_LAST)) state_in = ST_MCX;
            else cnt_in = cnt_ff + 1'b1;
         end
         // Coordinates and arc advance.
         ST_MCX: begin
            cmd.op   = OP_MUL_CX;
            state_in = ST_MSY;
         end
         ST_MSY: begin
            cmd.op   = OP_MUL_SY;
            state_in = ST_MINC;
         end
         ST_MINC: begin
            cmd.op   = OP_MUL_INC;
            state_in = ST_ADV;
         end
         ST_ADV: begin
            if (slot_free) begin
               cmd.op   = OP_ADV;
               issue    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = issue || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/svg_checker.sv =====
// Port-level checks of the spiral vertex generator, bound to the top level.
module svg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] vertex_x,
   input logic [23:0] vertex_y,
   input logic        last_vertex,
   input logic        bad_radii
);

   // A stalled result transaction keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(vertex_x) &&
         $stable(vertex_y) && $stable(last_vertex) && $stable(bad_radii))
      else $error("stalled result changed");

   // A bad-radii result is a zero vertex that ends the walk.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && bad_radii |-> last_vertex && vertex_x == 24'd0 && vertex_y == 24'd0)
      else $error("bad radii result not zero and last");

   // The engine works on one request at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // No result appears in the cycle right after a request transaction.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result too early");

endmodule

bind spiral_vertex_generator_core svg_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .vertex_x    (rsp_ch.vertex_x),
   .vertex_y    (rsp_ch.vertex_y),
   .last_vertex (rsp_ch.last_vertex),
   .bad_radii   (rsp_ch.bad_radii)
);
